// ----- sv/lfr_pkg.sv -----
// lfr_pkg: shared types, codes and helpers of the lin frame receiver
// used by lfr_frame_engine, lfr_result_seq and lin_frame_receiver_unit
`default_nettype none

package lfr_pkg;

  localparam int DEF_MAX_DATA_BYTES = 8;
  localparam logic [7:0] DEF_SYNC_MISS_LIMIT = 8'd100;
  localparam logic DEF_ENHANCED_CHECKSUM = 1'b0;
  localparam logic [7:0] SYNC_BYTE = 8'h55;
  // raw data sum plus identifier never exceeds 12 bits for up to eight bytes
  localparam int SUM_W = 12;

  // input actions
  localparam logic [1:0] ACT_BREAK = 2'd0;
  localparam logic [1:0] ACT_BYTE = 2'd1;
  localparam logic [1:0] ACT_TIMEOUT = 2'd2;
  localparam logic [1:0] ACT_HEADER = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NODATA = 3'd1;
  localparam logic [2:0] ST_CHKSUM = 3'd2;
  localparam logic [2:0] ST_PARITY = 3'd3;
  localparam logic [2:0] ST_SYNC = 3'd4;

  // configuration register indexes
  localparam logic CFG_ENHANCED = 1'b0;
  localparam logic CFG_MISS_LIMIT = 1'b1;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_SYNC = 4'b0010,
    PH_PID  = 4'b0100,
    PH_RESP = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic [3:0] frame_length;
    logic [5:0] request_id;
  } in_item_t;

  typedef struct packed {
    logic [5:0] msg_id;
    logic [7:0] data_byte;
    logic [2:0] byte_index;
    logic [3:0] data_count;
    logic [7:0] received_checksum;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       enhanced_checksum;
    logic [7:0] sync_miss_limit;
  } cfg_t;

  // one frame outcome handed to the result sequencer
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] msg_id;
    logic [3:0] data_count;
    logic [7:0] received_checksum;
  } job_t;

  function automatic logic [7:0] with_parity(logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // end-around-carry fold down to one byte
  function automatic logic [7:0] fold_sum(logic [SUM_W-1:0] s);
    logic [8:0] f1;
    logic [8:0] f2;
    f1 = {1'b0, s[7:0]} + {5'b0, s[SUM_W-1:8]};
    f2 = {1'b0, f1[7:0]} + {8'b0, f1[8]};
    return f2[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/lfr_frame_engine.sv -----
// lfr_frame_engine: input register, frame state machine, byte store and checksum
// depends on lfr_pkg
`default_nettype none

module lfr_frame_engine #(
  parameter int MAX_DATA_BYTES = lfr_pkg::DEF_MAX_DATA_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire lfr_pkg::in_item_t               in_data,
  input  wire lfr_pkg::cfg_t                   cfg,
  output logic                                 job_valid,
  input  wire logic                            job_ready,
  output lfr_pkg::job_t                        job,
  output logic [MAX_DATA_BYTES-1:0][7:0]       job_data
);

  localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
  localparam logic [3:0] MAX_CNT = 4'(MAX_DATA_BYTES);

  logic              in_valid_r;
  lfr_pkg::in_item_t in_r;

  lfr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  pid_r, pid_nxt;
  logic [3:0]  exp_r, exp_nxt;
  logic [3:0]  rc_r, rc_nxt;
  logic [7:0]  newest_r, newest_nxt;
  logic [7:0]  miss_r, miss_nxt;
  logic [lfr_pkg::SUM_W-1:0] sum_all_r, sum_all_nxt;
  logic [lfr_pkg::SUM_W-1:0] sum_prev_r, sum_prev_nxt;
  logic [MAX_DATA_BYTES-1:0][7:0] store_r;

  logic          store_we;
  logic          job_fire;
  logic          advance;
  lfr_pkg::job_t job_nxt;
  logic [3:0]    len_clamped;

  logic          is_to;
  logic          fin_small;
  logic [3:0]    fin_len;
  logic [7:0]    fin_chk;
  logic [lfr_pkg::SUM_W-1:0] fin_raw;
  logic [lfr_pkg::SUM_W-1:0] fin_total;
  logic          fin_good;
  lfr_pkg::job_t fin_job;

  assign advance  = in_valid_r && (!job_fire || job_ready);
  assign in_stall = in_valid_r && !advance;

  assign job_valid = in_valid_r && job_fire;
  assign job       = job_nxt;
  assign job_data  = store_r;

  assign len_clamped = (in_r.frame_length > MAX_CNT) ? MAX_CNT : in_r.frame_length;

  // response check, for a timeout or for a byte past the expected data
  always_comb begin
    is_to     = (in_r.action == lfr_pkg::ACT_TIMEOUT);
    fin_small = is_to ? (rc_r < 4'd2) : (rc_r == 4'd0);
    fin_len   = is_to ? (rc_r - 4'd1) : rc_r;
    fin_chk   = is_to ? newest_r : in_r.rx_byte;
    fin_raw   = is_to ? sum_prev_r : sum_all_r;
    fin_total = fin_raw + (cfg.enhanced_checksum ? lfr_pkg::SUM_W'(pid_r)
                                                 : lfr_pkg::SUM_W'(0));
    fin_good  = (~lfr_pkg::fold_sum(fin_total) == fin_chk);
    fin_job   = '0;
    fin_job.msg_id = pid_r[5:0];
    if (fin_small) begin
      fin_job.status = lfr_pkg::ST_NODATA;
    end else begin
      fin_job.status            = fin_good ? lfr_pkg::ST_OK : lfr_pkg::ST_CHKSUM;
      fin_job.data_count        = fin_len;
      fin_job.received_checksum = fin_chk;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    pid_nxt      = pid_r;
    exp_nxt      = exp_r;
    rc_nxt       = rc_r;
    newest_nxt   = newest_r;
    miss_nxt     = miss_r;
    sum_all_nxt  = sum_all_r;
    sum_prev_nxt = sum_prev_r;
    store_we     = 1'b0;
    job_fire     = 1'b0;
    job_nxt      = '0;
    if (in_r.action == lfr_pkg::ACT_BREAK) begin
      exp_nxt   = len_clamped;
      phase_nxt = lfr_pkg::PH_SYNC;
      miss_nxt  = 8'd0;
      rc_nxt    = 4'd0;
    end else if (in_r.action == lfr_pkg::ACT_HEADER) begin
      exp_nxt      = len_clamped;
      pid_nxt      = lfr_pkg::with_parity(in_r.request_id);
      phase_nxt    = lfr_pkg::PH_RESP;
      rc_nxt       = 4'd0;
      sum_all_nxt  = '0;
      sum_prev_nxt = '0;
    end else begin
      unique case (phase_r)
        lfr_pkg::PH_SYNC: begin
          if (in_r.action == lfr_pkg::ACT_BYTE) begin
            if (in_r.rx_byte == lfr_pkg::SYNC_BYTE) begin
              phase_nxt = lfr_pkg::PH_PID;
            end
          end else if (miss_r >= cfg.sync_miss_limit) begin
            phase_nxt      = lfr_pkg::PH_IDLE;
            job_fire       = 1'b1;
            job_nxt.status = lfr_pkg::ST_SYNC;
          end else begin
            miss_nxt = miss_r + 8'd1;
          end
        end
        lfr_pkg::PH_PID: begin
          if (in_r.action == lfr_pkg::ACT_TIMEOUT) begin
            phase_nxt      = lfr_pkg::PH_IDLE;
            job_fire       = 1'b1;
            job_nxt.status = lfr_pkg::ST_PARITY;
          end else if (lfr_pkg::with_parity(in_r.rx_byte[5:0]) != in_r.rx_byte) begin
            phase_nxt      = lfr_pkg::PH_IDLE;
            job_fire       = 1'b1;
            job_nxt.status = lfr_pkg::ST_PARITY;
            job_nxt.msg_id = in_r.rx_byte[5:0];
          end else begin
            pid_nxt      = in_r.rx_byte;
            rc_nxt       = 4'd0;
            sum_all_nxt  = '0;
            sum_prev_nxt = '0;
            phase_nxt    = lfr_pkg::PH_RESP;
          end
        end
        lfr_pkg::PH_RESP: begin
          if (in_r.action == lfr_pkg::ACT_BYTE) begin
            newest_nxt = in_r.rx_byte;
          end
          if (in_r.action == lfr_pkg::ACT_BYTE && rc_r < exp_r && rc_r < MAX_CNT) begin
            store_we     = 1'b1;
            rc_nxt       = rc_r + 4'd1;
            sum_prev_nxt = sum_all_r;
            sum_all_nxt  = sum_all_r + lfr_pkg::SUM_W'(in_r.rx_byte);
          end else begin
            phase_nxt = lfr_pkg::PH_IDLE;
            job_fire  = 1'b1;
            job_nxt   = fin_job;
          end
        end
        default: begin
          // idle: bytes and timeouts are ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= lfr_pkg::PH_IDLE;
      pid_r      <= 8'd0;
      exp_r      <= 4'd0;
      rc_r       <= 4'd0;
      newest_r   <= 8'd0;
      miss_r     <= 8'd0;
      sum_all_r  <= '0;
      sum_prev_r <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        phase_r    <= phase_nxt;
        pid_r      <= pid_nxt;
        exp_r      <= exp_nxt;
        rc_r       <= rc_nxt;
        newest_r   <= newest_nxt;
        miss_r     <= miss_nxt;
        sum_all_r  <= sum_all_nxt;
        sum_prev_r <= sum_prev_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (advance && store_we) begin
      store_r[rc_r[IDX_W-1:0]] <= in_r.rx_byte;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rc_r <= exp_r && rc_r <= MAX_CNT)
    else $error("received count beyond expected length");

  a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_r))
    else $error("blocked transaction lost from input register");

  a_job_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && !job_ready |-> in_stall)
    else $error("frame outcome dropped while result slot busy");
`endif

endmodule

`default_nettype wire

// ----- sv/lfr_result_seq.sv -----
// lfr_result_seq: holds one frame outcome and plays it out one result per cycle unless stalled
// depends on lfr_pkg
`default_nettype none

module lfr_result_seq #(
  parameter int MAX_DATA_BYTES = lfr_pkg::DEF_MAX_DATA_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            job_valid,
  output logic                                 job_ready,
  input  wire lfr_pkg::job_t                   job,
  input  wire logic [MAX_DATA_BYTES-1:0][7:0]  job_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output lfr_pkg::out_item_t                   out_data
);

  localparam int IDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  logic                           job_valid_r;
  lfr_pkg::job_t                  job_r;
  logic [MAX_DATA_BYTES-1:0][7:0] data_r;
  logic [2:0]                     idx_r;
  logic                           out_valid_r;
  lfr_pkg::out_item_t             out_r;

  logic               out_free;
  logic               load;
  logic               is_ok;
  logic               job_last;
  lfr_pkg::out_item_t item_nxt;

  assign out_free  = !out_valid_r || !out_stall;
  assign load      = job_valid_r && out_free;
  assign is_ok     = (job_r.status == lfr_pkg::ST_OK);
  assign job_last  = !is_ok || ({1'b0, idx_r} == job_r.data_count - 4'd1);
  assign job_ready = !job_valid_r || (load && job_last);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    item_nxt                   = '0;
    item_nxt.msg_id            = job_r.msg_id;
    item_nxt.data_byte         = is_ok ? data_r[idx_r[IDX_W-1:0]] : 8'd0;
    item_nxt.byte_index        = idx_r;
    item_nxt.data_count        = job_r.data_count;
    item_nxt.received_checksum = job_r.received_checksum;
    item_nxt.status            = job_r.status;
    item_nxt.last              = job_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      if (job_ready) begin
        job_valid_r <= job_valid;
      end
      if (job_ready && job_valid) begin
        idx_r <= 3'd0;
      end else if (load) begin
        idx_r <= idx_r + 3'd1;
      end
      if (out_free) begin
        out_valid_r <= job_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      job_r  <= job;
      data_r <= job_data;
    end
    if (load) begin
      out_r <= item_nxt;
    end
  end

`ifndef SYNTHESIS
  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> out_valid)
    else $error("gap inside a frame's result burst");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid_r && is_ok |-> {1'b0, idx_r} < job_r.data_count)
    else $error("result index past data count");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != lfr_pkg::ST_OK |-> out_data.last
      && out_data.byte_index == 3'd0 && out_data.data_byte == 8'd0)
    else $error("status result not a lone final result");
`endif

endmodule

`default_nettype wire

// ----- sv/lin_frame_receiver_unit.sv -----
// lin_frame_receiver_unit: top level of the lin frame receiver, holds the config registers
// depends on lfr_pkg, lfr_frame_engine and lfr_result_seq
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_stall   lfr_pkg::in_item_t
//   out_     output     out_valid / out_stall lfr_pkg::out_item_t
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// one item per cycle enters the input register unless the input stalls, and is processed from there
// an outcome passes the job register and then the output register; a good frame gives one result
//   per cycle for each data byte unless stalled, so a new frame outcome waits for the previous burst
// the input stalls only when an item would produce results while the result slot is full
// reset (synchronous, active low) returns to idle with config at default values
`default_nettype none

module lin_frame_receiver_unit #(
  parameter int MAX_DATA_BYTES = lfr_pkg::DEF_MAX_DATA_BYTES
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire lfr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output lfr_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [7:0]         cfg_wdata
);

  lfr_pkg::cfg_t cfg_r;

  logic                           job_valid;
  logic                           job_ready;
  lfr_pkg::job_t                  job;
  logic [MAX_DATA_BYTES-1:0][7:0] job_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enhanced_checksum <= lfr_pkg::DEF_ENHANCED_CHECKSUM;
      cfg_r.sync_miss_limit   <= lfr_pkg::DEF_SYNC_MISS_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lfr_pkg::CFG_ENHANCED:   cfg_r.enhanced_checksum <= cfg_wdata[0];
        lfr_pkg::CFG_MISS_LIMIT: cfg_r.sync_miss_limit   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  lfr_frame_engine #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .job_data  (job_data)
  );

  lfr_result_seq #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .job_data  (job_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
